// ----- rtl/core/rhc_pkg.sv -----
// shared types, widths and codes for the rgb to hsv converter
package rhc_pkg;

	localparam int COMPONENT_BITS = 12;
	localparam int HUE_FRAC_BITS  = 6;
	localparam int HUE_BITS       = 9 + HUE_FRAC_BITS;
	localparam int QUO_BITS       = (HUE_BITS > COMPONENT_BITS) ? HUE_BITS : COMPONENT_BITS;
	localparam int DIV_BITS       = COMPONENT_BITS + QUO_BITS;
	localparam int NUM_BITS       = COMPONENT_BITS + 10;
	localparam int HUE_LIMIT      = 360 << HUE_FRAC_BITS;
	localparam int PIPE_DEPTH     = 3 + QUO_BITS;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} rhc_sector_t;

	typedef struct packed {
		logic [COMPONENT_BITS-1:0] red;
		logic [COMPONENT_BITS-1:0] green;
		logic [COMPONENT_BITS-1:0] blue;
		logic [COMPONENT_BITS-1:0] alpha;
	} rhc_rgba_t;

	typedef struct packed {
		logic [HUE_BITS-1:0]       hue;
		logic [COMPONENT_BITS-1:0] saturation;
		logic [COMPONENT_BITS-1:0] value;
		logic [COMPONENT_BITS-1:0] alpha_out;
	} rhc_hsva_t;

	typedef struct packed {
		logic                      gray;
		logic [COMPONENT_BITS-1:0] value;
		logic [COMPONENT_BITS-1:0] alpha;
	} rhc_side_t;

endpackage

// ----- rtl/core/rgb_to_hsv_convert.sv -----
// top level of the rgb to hsv converter
// Converts one RGBA pixel per clock into hue, saturation, value and alpha.
// Request channel: a pixel on rgba is taken at a rising edge with start high
// and busy low. busy is always low, so a new request may come every cycle.
// Result channel: done is high for exactly one cycle with the converted pixel
// on result; the receiver takes it at the edge that ends that cycle.
// Pipeline: three front stages plus one stage per quotient bit of the 15-bit
// hue divider; saturation is divided alongside in a second divider.
// Throughput: one pixel per cycle, results leave in request order.
// Gray or black pixels give zero hue and saturation.
// Reset clears all valid bits, so no result strobe follows reset until
// a new request is taken. The receiver cannot stall: results are never held.
module rgb_to_hsv_convert (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rhc_pkg::rhc_rgba_t rgba,
	output logic               done,
	output rhc_pkg::rhc_hsva_t result
);

	localparam int QB = rhc_pkg::QUO_BITS;
	localparam int CB = rhc_pkg::COMPONENT_BITS;
	localparam int HB = rhc_pkg::HUE_BITS;

	logic                         req;
	logic                         front_valid;
	logic [CB-1:0]                den;
	logic [rhc_pkg::DIV_BITS-1:0] hue_num;
	logic [rhc_pkg::DIV_BITS-1:0] sat_num;
	rhc_pkg::rhc_side_t           front_side;
	logic [QB-1:0]                hue_quo;
	logic [QB-1:0]                sat_quo;

	logic                         dvalid_s [1:QB];
	rhc_pkg::rhc_side_t           dside_s  [1:QB];

	assign busy = 1'b0;
	assign req  = start && !busy;

	rhc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (req),
		.rgba    (rgba),
		.valid   (front_valid),
		.den     (den),
		.hue_num (hue_num),
		.sat_num (sat_num),
		.side    (front_side)
	);

	rhc_div u_hue_div (
		.clk (clk),
		.num (hue_num),
		.den (den),
		.quo (hue_quo)
	);

	// saturation divides by the largest component
	rhc_div u_sat_div (
		.clk (clk),
		.num (sat_num),
		.den (front_side.value),
		.quo (sat_quo)
	);

	// sideband travels beside the divider stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= QB; i++) begin
				dvalid_s[i] <= 1'b0;
			end
		end else begin
			dvalid_s[1] <= front_valid;
			for (int i = 2; i <= QB; i++) begin
				dvalid_s[i] <= dvalid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		dside_s[1] <= front_side;
		for (int i = 2; i <= QB; i++) begin
			dside_s[i] <= dside_s[i-1];
		end
	end

	assign done              = dvalid_s[QB];
	assign result.hue        = dside_s[QB].gray ? '0 : hue_quo[HB-1:0];
	assign result.saturation = dside_s[QB].gray ? '0 : sat_quo[CB-1:0];
	assign result.value      = dside_s[QB].value;
	assign result.alpha_out  = dside_s[QB].alpha;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(rhc_pkg::PIPE_DEPTH) done)
		else $error("request did not produce a result on time");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hue < HB'(rhc_pkg::HUE_LIMIT)))
		else $error("hue out of range");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturation == '0) |-> (result.hue == '0))
		else $error("hue set on a gray pixel");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(dvalid_s[QB-1]))
		else $error("result strobe without a request in flight");
`endif

endmodule

// ----- rtl/core/rhc_front.sv -----
// front stages: max/min and sector pick, hue numerator, wrap and dividend setup
module rhc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  rhc_pkg::rhc_rgba_t                  rgba,
	output logic                                valid,
	output logic [rhc_pkg::COMPONENT_BITS-1:0]  den,
	output logic [rhc_pkg::DIV_BITS-1:0]        hue_num,
	output logic [rhc_pkg::DIV_BITS-1:0]        sat_num,
	output rhc_pkg::rhc_side_t                  side
);

	localparam int CB = rhc_pkg::COMPONENT_BITS;
	localparam int NB = rhc_pkg::NUM_BITS;

	logic [CB-1:0]          hi_c;
	logic [CB-1:0]          lo_c;
	rhc_pkg::rhc_sector_t   sect_c;
	logic signed [CB:0]     diff_c;

	logic                   valid_s1;
	logic [CB-1:0]          hi_s1;
	logic [CB-1:0]          spread_s1;
	rhc_pkg::rhc_sector_t   sect_s1;
	logic signed [CB:0]     diff_s1;
	logic [CB-1:0]          alpha_s1;

	logic signed [NB-1:0]   spread_ext;
	logic signed [NB-1:0]   diff_ext;
	logic signed [NB-1:0]   base_c;
	logic signed [NB-1:0]   num_c;
	logic signed [NB-1:0]   s360_c;
	logic [2*CB-1:0]        satnum_c;

	logic                   valid_s2;
	logic signed [NB-1:0]   num_s2;
	logic signed [NB-1:0]   s360_s2;
	logic [2*CB-1:0]        satnum_s2;
	logic [CB-1:0]          spread_s2;
	rhc_pkg::rhc_side_t     side_s2;

	logic signed [NB-1:0]   wrap_c;
	logic [CB+8:0]          wrap_u;

	logic                   valid_s3;
	logic [CB-1:0]          den_s3;
	logic [rhc_pkg::DIV_BITS-1:0] hue_num_s3;
	logic [rhc_pkg::DIV_BITS-1:0] sat_num_s3;
	rhc_pkg::rhc_side_t     side_s3;

	// stage 1: extremes and sector, ties go red then green
	always_comb begin
		hi_c = (rgba.red > rgba.green) ? rgba.red : rgba.green;
		hi_c = (hi_c > rgba.blue) ? hi_c : rgba.blue;
		lo_c = (rgba.red < rgba.green) ? rgba.red : rgba.green;
		lo_c = (lo_c < rgba.blue) ? lo_c : rgba.blue;
		if (rgba.red >= hi_c) begin
			sect_c = rhc_pkg::SECT_RED;
			diff_c = $signed({1'b0, rgba.green}) - $signed({1'b0, rgba.blue});
		end else if (rgba.green >= hi_c) begin
			sect_c = rhc_pkg::SECT_GREEN;
			diff_c = $signed({1'b0, rgba.blue}) - $signed({1'b0, rgba.red});
		end else begin
			sect_c = rhc_pkg::SECT_BLUE;
			diff_c = $signed({1'b0, rgba.red}) - $signed({1'b0, rgba.green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		hi_s1     <= hi_c;
		spread_s1 <= hi_c - lo_c;
		sect_s1   <= sect_c;
		diff_s1   <= diff_c;
		alpha_s1  <= rgba.alpha;
	end

	// stage 2: sector base plus 60 times difference, 360 times spread, saturation numerator
	assign spread_ext = $signed(NB'(spread_s1));
	assign diff_ext   = NB'(diff_s1);
	assign s360_c     = (spread_ext <<< 8) + (spread_ext <<< 6) + (spread_ext <<< 5)
		+ (spread_ext <<< 3);
	assign satnum_c   = {spread_s1, {CB{1'b0}}} - (2*CB)'(spread_s1);

	always_comb begin
		case (sect_s1)
			rhc_pkg::SECT_RED:   base_c = '0;
			rhc_pkg::SECT_GREEN: base_c = (spread_ext <<< 7) - (spread_ext <<< 3);
			rhc_pkg::SECT_BLUE:  base_c = (spread_ext <<< 8) - (spread_ext <<< 4);
			default:             base_c = '0;
		endcase
		num_c = base_c + (diff_ext <<< 6) - (diff_ext <<< 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		num_s2        <= num_c;
		s360_s2       <= s360_c;
		satnum_s2     <= satnum_c;
		spread_s2     <= spread_s1;
		side_s2.gray  <= (spread_s1 == '0);
		side_s2.value <= hi_s1;
		side_s2.alpha <= alpha_s1;
	end

	// stage 3: wrap negative hue, scale by fraction bits
	assign wrap_c = num_s2[NB-1] ? (num_s2 + s360_s2) : num_s2;
	assign wrap_u = wrap_c[CB+8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		den_s3     <= spread_s2;
		hue_num_s3 <= rhc_pkg::DIV_BITS'(wrap_u) << rhc_pkg::HUE_FRAC_BITS;
		sat_num_s3 <= rhc_pkg::DIV_BITS'(satnum_s2);
		side_s3    <= side_s2;
	end

	assign valid   = valid_s3;
	assign den     = den_s3;
	assign hue_num = hue_num_s3;
	assign sat_num = sat_num_s3;
	assign side    = side_s3;

endmodule

// ----- rtl/core/rhc_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module rhc_div (
	input  logic                                clk,
	input  logic [rhc_pkg::DIV_BITS-1:0]        num,
	input  logic [rhc_pkg::COMPONENT_BITS-1:0]  den,
	output logic [rhc_pkg::QUO_BITS-1:0]        quo
);

	localparam int QB = rhc_pkg::QUO_BITS;
	localparam int WB = rhc_pkg::DIV_BITS;
	localparam int CB = rhc_pkg::COMPONENT_BITS;

	logic [WB-1:0] rem_s [1:QB];
	logic [QB-1:0] quo_s [1:QB];
	logic [CB-1:0] den_s [1:QB];

	for (genvar i = 0; i < QB; i++) begin : g_stage
		logic [WB-1:0] cur_rem;
		logic [QB-1:0] cur_quo;
		logic [CB-1:0] cur_den;
		logic [WB-1:0] trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign cur_rem = num;
			assign cur_quo = '0;
			assign cur_den = den;
		end else begin : g_next
			assign cur_rem = rem_s[i];
			assign cur_quo = quo_s[i];
			assign cur_den = den_s[i];
		end

		assign trial = WB'(cur_den) << (QB - 1 - i);
		assign ge    = (cur_rem >= trial);

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? (cur_rem - trial) : cur_rem;
			quo_s[i+1] <= {cur_quo[QB-2:0], ge};
			den_s[i+1] <= cur_den;
		end
	end

	assign quo = quo_s[QB];

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the rgb to hsv converter
module tb;

	localparam int CB    = rhc_pkg::COMPONENT_BITS;
	localparam int HB    = rhc_pkg::HUE_BITS;
	localparam int HF    = rhc_pkg::HUE_FRAC_BITS;
	localparam int FULL  = (1 << CB) - 1;
	localparam int DRAIN = 40;

	typedef struct {
		rhc_pkg::rhc_rgba_t px;
		bit                 typed;
		rhc_pkg::rhc_hsva_t want;
	} pixel_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	rhc_pkg::rhc_rgba_t rgba;
	logic               done;
	rhc_pkg::rhc_hsva_t result;

	bit                 typed_on;
	rhc_pkg::rhc_hsva_t typed_want;
	rhc_pkg::rhc_hsva_t pending_hsv[$];
	pixel_row_t         pixel_rows[$];
	int                 errors;

	rgb_to_hsv_convert u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.rgba   (rgba),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic rhc_pkg::rhc_hsva_t predict_hsv(rhc_pkg::rhc_rgba_t px);
		rhc_pkg::rhc_hsva_t   res;
		rhc_pkg::rhc_sector_t sect;
		longint               r, g, b, hi, lo, spread, num, base, diff, hue, sat;
		r = longint'(px.red);
		g = longint'(px.green);
		b = longint'(px.blue);
		hi = (r > g) ? r : g;
		hi = (hi > b) ? hi : b;
		lo = (r < g) ? r : g;
		lo = (lo < b) ? lo : b;
		spread = hi - lo;
		hue = 0;
		sat = 0;
		if (spread != 0 && hi != 0) begin
			sat = (spread * longint'(FULL)) / hi;
			if (r >= hi)
				sect = rhc_pkg::SECT_RED;
			else if (g >= hi)
				sect = rhc_pkg::SECT_GREEN;
			else
				sect = rhc_pkg::SECT_BLUE;
			case (sect)
				rhc_pkg::SECT_RED: begin
					base = 0;
					diff = g - b;
				end
				rhc_pkg::SECT_GREEN: begin
					base = 120;
					diff = b - r;
				end
				default: begin
					base = 240;
					diff = r - g;
				end
			endcase
			num = base * spread + 60 * diff;
			if (num < 0)
				num += 360 * spread;
			hue = (num << HF) / spread;
		end
		res.hue        = hue[HB-1:0];
		res.saturation = sat[CB-1:0];
		res.value      = hi[CB-1:0];
		res.alpha_out  = px.alpha;
		return res;
	endfunction

	function automatic rhc_pkg::rhc_rgba_t rand_pixel();
		rhc_pkg::rhc_rgba_t px;
		int                 mode, v, base, pick;
		int                 c [3];
		mode = $urandom_range(0, 5);
		px.alpha = CB'($urandom_range(0, FULL));
		for (int i = 0; i < 3; i++)
			c[i] = $urandom_range(0, FULL);
		case (mode)
			1: begin
				v = $urandom_range(0, FULL);
				for (int i = 0; i < 3; i++)
					c[i] = v;
			end
			2: begin
				v = $urandom_range(0, FULL);
				pick = $urandom_range(0, 2);
				for (int i = 0; i < 3; i++)
					c[i] = (i == pick) ? $urandom_range(0, v) : v;
			end
			3: begin
				base = $urandom_range(0, FULL);
				for (int i = 0; i < 3; i++) begin
					c[i] = base + $urandom_range(0, 3);
					if (c[i] > FULL)
						c[i] = FULL;
				end
			end
			4: begin
				for (int i = 0; i < 3; i++) begin
					case ($urandom_range(0, 3))
						0: c[i] = 0;
						1: c[i] = FULL;
						2: c[i] = 1;
						default: c[i] = $urandom_range(0, FULL);
					endcase
				end
				px.alpha = $urandom_range(0, 1) ? CB'(FULL) : '0;
			end
			5: begin
				for (int i = 0; i < 3; i++)
					c[i] = $urandom_range(0, 7);
			end
			default: ;
		endcase
		px.red   = CB'(c[0]);
		px.green = CB'(c[1]);
		px.blue  = CB'(c[2]);
		return px;
	endfunction

	task automatic report(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// model of the result side: expectations are made at the accepting edge
	always @(posedge clk) begin : result_check
		rhc_pkg::rhc_hsva_t want;
		if (done) begin
			if (pending_hsv.size() == 0) begin
				report($sformatf("unexpected result %h", result));
			end else begin
				want = pending_hsv.pop_front();
				if (result.hue !== want.hue)
					report($sformatf("hue %0d, want %0d", result.hue, want.hue));
				if (result.saturation !== want.saturation)
					report($sformatf("saturation %0d, want %0d",
						result.saturation, want.saturation));
				if (result.value !== want.value)
					report($sformatf("value %0d, want %0d", result.value, want.value));
				if (result.alpha_out !== want.alpha_out)
					report($sformatf("alpha_out %0d, want %0d",
						result.alpha_out, want.alpha_out));
			end
		end
		if (arst_n && start && !busy)
			pending_hsv.push_back(typed_on ? typed_want : predict_hsv(rgba));
	end

	// called just after a falling edge, returns just after a falling edge
	task automatic send_pixel(rhc_pkg::rhc_rgba_t px, int idle_pct, bit typed = 0,
			rhc_pkg::rhc_hsva_t want = '0);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			rgba  <= rand_pixel();
			@(negedge clk);
		end
		start      <= 1'b1;
		rgba       <= px;
		typed_on   <= typed;
		typed_want <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_hsv.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_row(int r, int g, int b, int a, bit typed = 0,
			int h = 0, int s = 0, int v = 0);
		pixel_row_t row;
		row.px.red          = CB'(r);
		row.px.green        = CB'(g);
		row.px.blue         = CB'(b);
		row.px.alpha        = CB'(a);
		row.typed           = typed;
		row.want.hue        = HB'(h);
		row.want.saturation = CB'(s);
		row.want.value      = CB'(v);
		row.want.alpha_out  = CB'(a);
		pixel_rows.push_back(row);
	endtask

	task automatic run_random(int count, int idle_pct);
		for (int i = 0; i < count; i++) begin
			send_pixel(rand_pixel(), idle_pct);
			// hold off once in a while until the pipeline is empty
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	initial begin
		errors     = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		rgba       = '0;
		typed_on   = 1'b0;
		typed_want = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// black, white, gray and the primaries
		add_row(0, 0, 0, 0, 1, 0, 0, 0);
		add_row(0, 0, 0, FULL, 1, 0, 0, 0);
		add_row(FULL, FULL, FULL, 2048, 1, 0, 0, FULL);
		add_row(2000, 2000, 2000, 1, 1, 0, 0, 2000);
		add_row(FULL, 0, 0, FULL, 1, 0, FULL, FULL);
		add_row(0, FULL, 0, 0, 1, 120 << HF, FULL, FULL);
		add_row(0, 0, FULL, 100, 1, 240 << HF, FULL, FULL);
		add_row(1, 0, 0, 5, 1, 0, FULL, 1);
		add_row(0, 0, 1, 6, 1, 240 << HF, FULL, 1);
		// ties between the largest components
		add_row(FULL, FULL, 0, 7);
		add_row(0, FULL, FULL, 8);
		add_row(FULL, 0, FULL, 9);
		add_row(FULL, FULL, 1, 10);
		// red sector with negative hue wraps around
		add_row(FULL, 0, 1, 11);
		add_row(FULL, 0, FULL - 1, 12);
		// small spread and mixed values
		add_row(FULL, FULL - 1, FULL - 1, 13);
		add_row(FULL - 1, FULL, FULL, 14);
		add_row(1, 2, 3, 15);
		add_row(3000, 1000, 2000, 16);
		add_row(12'haaa, 12'h555, 12'hfff, 12'h555);
		add_row(12'h555, 12'haaa, 12'h000, 12'haaa);
		add_row(12'h800, 12'h7ff, 12'h001, 12'hfff);

		foreach (pixel_rows[i])
			send_pixel(pixel_rows[i].px, 0, pixel_rows[i].typed, pixel_rows[i].want);
		drain();

		run_random(150, 0);
		drain();
		run_random(150, 75);
		drain();
		run_random(200, 12);
		drain();

		repeat (DRAIN) @(negedge clk);
		if (pending_hsv.size() != 0)
			report($sformatf("%0d results never arrived", pending_hsv.size()));
		if (errors == 0)
			$display("rgb_to_hsv_convert: match");
		else
			$display("rgb_to_hsv_convert: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("rgb_to_hsv_convert: mismatch");
		$finish;
	end

endmodule
